// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: operand and
// result widths, operation and status codes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int IN_W          = 16;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 31;

  localparam int OW = OPERAND_WIDTH;
  localparam int PROD_W = 2 * OW;
  localparam int PW = 2 * OW + 1;
  localparam int MW = 2 * OW;
  localparam int KW = $clog2(MW);
  localparam int CW = $clog2(MW + 1);

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_DEN_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_DEN_ZERO,
    RES_DIV_ZERO,
    RES_ZERO,
    RES_OK
  } res_kind_t;

  typedef enum logic [1:0] {
    MSEL_P1,
    MSEL_P2,
    MSEL_DEN
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMB,
    S_ZCHK,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      comb;
    logic      mag_load;
    logic      gcd_step;
    logic      div_load_num;
    logic      div_load_den;
    logic      div_step;
    logic      qn_save;
    logic      res_wr;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_zero;
    logic numer_zero;
    logic gcd_done;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- rtl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller of the rational arithmetic unit. It steps one request through
// operand checks, the shared multiplier, reduction and the two divisions.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);
  import rau_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.den_zero || stat.div_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_COMB;
      S_COMB: state_nxt = S_ZCHK;
      S_ZCHK: begin
        if (stat.numer_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (stat.div_done) begin
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MSEL_P1;
    cmd.res_kind = RES_OK;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      S_CHECK: begin
        cmd.res_wr = stat.den_zero || stat.div_zero;
        cmd.res_kind = stat.den_zero ? RES_DEN_ZERO : RES_DIV_ZERO;
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_P1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_P2;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MSEL_DEN;
      end
      S_COMB: cmd.comb = 1'b1;
      S_ZCHK: begin
        cmd.mag_load = 1'b1;
        cmd.res_wr = stat.numer_zero;
        cmd.res_kind = RES_ZERO;
      end
      S_GCD: begin
        cmd.gcd_step = !stat.gcd_done;
        cmd.div_load_num = stat.gcd_done;
      end
      S_DIVN: begin
        cmd.div_step = !stat.div_done;
        cmd.qn_save = stat.div_done;
        cmd.div_load_den = stat.div_done;
      end
      S_DIVD: begin
        cmd.div_step = !stat.div_done;
        cmd.res_wr = stat.div_done;
        cmd.res_kind = RES_OK;
      end
      S_DONE: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- rtl/rau_datapath.sv -----
// ----------------------------------------------------------------------------
// rau_datapath
// Datapath of the rational arithmetic unit: operand registers, one shared
// signed multiplier, the combine adder, a binary GCD unit and a restoring
// divider that is used for the numerator and then the denominator.
// ----------------------------------------------------------------------------
module rau_datapath (
  input  logic                        clk,
  input  rau_pkg::dp_cmd_t            cmd,
  input  logic [1:0]                  in_action,
  input  logic [rau_pkg::IN_W-1:0]    in_num_a,
  input  logic [rau_pkg::IN_W-1:0]    in_den_a,
  input  logic [rau_pkg::IN_W-1:0]    in_num_b,
  input  logic [rau_pkg::IN_W-1:0]    in_den_b,
  output rau_pkg::dp_stat_t           stat,
  output logic [1:0]                  out_status,
  output logic [rau_pkg::NUM_W-1:0]   out_num_out,
  output logic [rau_pkg::DEN_W-1:0]   out_den_out
);
  import rau_pkg::*;

  action_t                   act_r;
  logic signed [OW-1:0]      na_r, da_r, nb_r, db_r;
  logic signed [OW-1:0]      ma, mb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  p1_r, p2_r, pd_r;
  logic signed [PW-1:0]      numer_r, numer_nxt, denom_r;
  logic [PW-1:0]             nabs, dabs;
  logic [MW-1:0]             nmag_r, dmag_r;
  logic                      neg_r;
  logic [MW-1:0]             u_r, v_r, diff, umin;
  logic [KW-1:0]             k_r;
  logic [MW-1:0]             g_r, rem_r, quo_r, qn_r;
  logic [CW-1:0]             cnt_r;
  logic [MW:0]               shifted;
  logic                      ge;
  logic [NUM_W-1:0]          qn_ext;
  status_t                   res_status_r;
  logic [NUM_W-1:0]          res_num_r;
  logic [DEN_W-1:0]          res_den_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_action);
      na_r  <= in_num_a[OW-1:0];
      da_r  <= in_den_a[OW-1:0];
      nb_r  <= in_num_b[OW-1:0];
      db_r  <= in_den_b[OW-1:0];
    end
  end

  always_comb begin
    ma = na_r;
    mb = db_r;
    case (cmd.mul_sel)
      MSEL_P1: begin
        ma = na_r;
        mb = (act_r == ACT_MUL) ? nb_r : db_r;
      end
      MSEL_P2: begin
        ma = nb_r;
        mb = da_r;
      end
      MSEL_DEN: begin
        ma = da_r;
        mb = (act_r == ACT_DIV) ? nb_r : db_r;
      end
      default: begin
        ma = na_r;
        mb = db_r;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MSEL_P1:  p1_r <= prod;
        MSEL_P2:  p2_r <= prod;
        MSEL_DEN: pd_r <= prod;
        default:  p1_r <= prod;
      endcase
    end
  end

  always_comb begin
    case (act_r)
      ACT_ADD: numer_nxt = PW'(p1_r) + PW'(p2_r);
      ACT_SUB: numer_nxt = PW'(p1_r) - PW'(p2_r);
      default: numer_nxt = PW'(p1_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      numer_r <= numer_nxt;
      denom_r <= PW'(pd_r);
    end
  end

  assign nabs = numer_r[PW-1] ? PW'(-numer_r) : PW'(numer_r);
  assign dabs = denom_r[PW-1] ? PW'(-denom_r) : PW'(denom_r);

  assign diff = (u_r > v_r) ? (u_r - v_r) : (v_r - u_r);
  assign umin = (u_r > v_r) ? v_r : u_r;

  always_ff @(posedge clk) begin
    if (cmd.mag_load) begin
      nmag_r <= nabs[MW-1:0];
      dmag_r <= dabs[MW-1:0];
      u_r    <= nabs[MW-1:0];
      v_r    <= dabs[MW-1:0];
      k_r    <= '0;
      neg_r  <= numer_r[PW-1] ^ denom_r[PW-1];
    end else if (cmd.gcd_step && (v_r != '0)) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else begin
        u_r <= umin;
        v_r <= diff;
      end
    end
  end

  assign shifted = {rem_r, quo_r[MW-1]};
  assign ge = shifted >= {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load_num) begin
      g_r   <= u_r << k_r;
      quo_r <= nmag_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_load_den) begin
      quo_r <= dmag_r;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? MW'(shifted - {1'b0, g_r}) : shifted[MW-1:0];
      quo_r <= {quo_r[MW-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.qn_save) begin
      qn_r <= quo_r;
    end
  end

  assign qn_ext = NUM_W'(qn_r);

  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      case (cmd.res_kind)
        RES_DEN_ZERO: begin
          res_status_r <= ST_DEN_ZERO;
          res_num_r    <= '0;
          res_den_r    <= '0;
        end
        RES_DIV_ZERO: begin
          res_status_r <= ST_DIV_ZERO;
          res_num_r    <= '0;
          res_den_r    <= '0;
        end
        RES_ZERO: begin
          res_status_r <= ST_OK;
          res_num_r    <= '0;
          res_den_r    <= (denom_r == '0) ? '0 : DEN_W'(1);
        end
        RES_OK: begin
          res_status_r <= ST_OK;
          res_num_r    <= neg_r ? (~qn_ext + NUM_W'(1)) : qn_ext;
          res_den_r    <= DEN_W'(quo_r);
        end
        default: begin
          res_status_r <= ST_OK;
          res_num_r    <= '0;
          res_den_r    <= '0;
        end
      endcase
    end
  end

  assign stat.den_zero   = (da_r == '0) || (db_r == '0);
  assign stat.div_zero   = (act_r == ACT_DIV) && (nb_r == '0);
  assign stat.numer_zero = (numer_r == '0) || (denom_r == '0);
  assign stat.gcd_done   = (v_r == '0);
  assign stat.div_done   = (cnt_r == CW'(MW));

  assign out_status  = res_status_r;
  assign out_num_out = res_num_r;
  assign out_den_out = res_den_r;

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two signed fractions and returns
// the result reduced by the greatest common divisor, with a status code.
//
//   Channel  Handshake          Payload
//   input    start, busy        in_action, in_num_a, in_den_a, in_num_b, in_den_b
//   result   out_valid          out_status, out_num_out, out_den_out
//
// A request is taken when start is high and busy is low. A zero denominator or
// a divide by zero returns after the operand check, a zero result after the
// multiplies and the combine step. Any other request also runs the binary GCD
// loop and two 32-step divisions on one divider before it returns.
// The result shows for one cycle with out_valid high while busy is still high.
// Reset is synchronous and returns the block to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_action,
  input  logic signed [rau_pkg::IN_W-1:0]  in_num_a,
  input  logic signed [rau_pkg::IN_W-1:0]  in_den_a,
  input  logic signed [rau_pkg::IN_W-1:0]  in_num_b,
  input  logic signed [rau_pkg::IN_W-1:0]  in_den_b,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic signed [rau_pkg::NUM_W-1:0] out_num_out,
  output logic [rau_pkg::DEN_W-1:0]   out_den_out
);
  import rau_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rau_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .in_action   (in_action),
    .in_num_a    (in_num_a),
    .in_den_a    (in_den_a),
    .in_num_b    (in_num_b),
    .in_den_b    (in_den_b),
    .stat        (stat),
    .out_status  (out_status),
    .out_num_out (out_num_out),
    .out_den_out (out_den_out)
  );

endmodule

// ----- rtl/rau_checker.sv -----
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_status,
  input logic [rau_pkg::NUM_W-1:0]   out_num_out,
  input logic [rau_pkg::DEN_W-1:0]   out_den_out
);
  import rau_pkg::*;

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result only appears while a request is in flight.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // An error result carries a zero fraction.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_num_out == '0) && (out_den_out == '0)))
    else $error("error result with nonzero fraction");

  // A good result has a positive denominator.
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |-> (out_den_out != '0))
    else $error("good result with zero denominator");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_num_out (out_num_out),
  .out_den_out (out_den_out)
);

// ----- verif/rau_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rau_tb_checker
// Watches the request and result channels of the rational arithmetic unit,
// predicts the reduced fraction and status of every accepted request and
// compares each result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rau_tb_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [rau_pkg::IN_W-1:0]      in_num_a,
  input  logic [rau_pkg::IN_W-1:0]      in_den_a,
  input  logic [rau_pkg::IN_W-1:0]      in_num_b,
  input  logic [rau_pkg::IN_W-1:0]      in_den_b,
  input  logic                          out_valid,
  input  logic [1:0]                    out_status,
  input  logic [rau_pkg::NUM_W-1:0]     out_num_out,
  input  logic [rau_pkg::DEN_W-1:0]     out_den_out,
  output int                            mismatches,
  output int                            pending,
  output int                            n_ok,
  output int                            n_div_zero,
  output int                            n_den_zero
);
  import rau_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } fraction_t;

  fraction_t awaited_fractions[$];

  function automatic logic [63:0] widen_operand(logic [IN_W-1:0] v);
    logic [63:0] x;
    x = 64'(v[OW-1:0]);
    if (v[OW-1]) x = x | ~((64'd1 << OW) - 64'd1);
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(action_t act, logic [IN_W-1:0] na_in,
                                                logic [IN_W-1:0] da_in,
                                                logic [IN_W-1:0] nb_in,
                                                logic [IN_W-1:0] db_in);
    fraction_t   r;
    logic [63:0] na, da, nb, db, numer, denom, nmag, dmag, a, g, t;
    logic        neg;
    na = widen_operand(na_in);
    da = widen_operand(da_in);
    nb = widen_operand(nb_in);
    db = widen_operand(db_in);
    r.status = ST_OK;
    r.num = '0;
    r.den = '0;
    if (da == 0 || db == 0) begin
      r.status = ST_DEN_ZERO;
      return r;
    end
    if (act == ACT_DIV && nb == 0) begin
      r.status = ST_DIV_ZERO;
      return r;
    end
    case (act)
      ACT_ADD: begin
        numer = na * db + nb * da;
        denom = da * db;
      end
      ACT_SUB: begin
        numer = na * db - nb * da;
        denom = da * db;
      end
      ACT_MUL: begin
        numer = na * nb;
        denom = da * db;
      end
      default: begin
        numer = na * db;
        denom = da * nb;
      end
    endcase
    if (numer == 0 || denom == 0) begin
      r.den = (denom == 0) ? '0 : DEN_W'(1);
      return r;
    end
    nmag = numer[63] ? 64'd0 - numer : numer;
    dmag = denom[63] ? 64'd0 - denom : denom;
    a = nmag;
    g = dmag;
    while (g != 0) begin
      t = a % g;
      a = g;
      g = t;
    end
    nmag = nmag / a;
    dmag = dmag / a;
    neg = numer[63] ^ denom[63];
    r.num = NUM_W'(neg ? 64'd0 - nmag : nmag);
    r.den = DEN_W'(dmag);
    return r;
  endfunction

  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      awaited_fractions.delete();
      mismatches <= 0;
      n_ok <= 0;
      n_div_zero <= 0;
      n_den_zero <= 0;
    end else begin
      if (out_valid) begin
        if (awaited_fractions.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request waiting: status %0d num %0d den %0d",
                     $realtime, out_status, $signed(out_num_out), out_den_out);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_fractions.pop_front();
          if (want.status !== out_status || want.num !== out_num_out ||
              want.den !== out_den_out) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected status %0d num %0d den %0d, got %0d %0d %0d",
                       $realtime, want.status, $signed(want.num), want.den,
                       out_status, $signed(out_num_out), out_den_out);
            mismatches <= mismatches + 1;
          end
          case (want.status)
            ST_OK:       n_ok <= n_ok + 1;
            ST_DIV_ZERO: n_div_zero <= n_div_zero + 1;
            default:     n_den_zero <= n_den_zero + 1;
          endcase
        end
      end
      if (start && !busy)
        awaited_fractions.push_back(reduce_fraction(action_t'(in_action), in_num_a,
                                                    in_den_a, in_num_b, in_den_b));
    end
    pending <= awaited_fractions.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random fraction requests into the rational arithmetic
// unit under several sender idling patterns and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import rau_pkg::*;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_REQUESTS = 1830;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [1:0]              in_action;
  logic signed [IN_W-1:0]  in_num_a;
  logic signed [IN_W-1:0]  in_den_a;
  logic signed [IN_W-1:0]  in_num_b;
  logic signed [IN_W-1:0]  in_den_b;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic signed [NUM_W-1:0] out_num_out;
  logic [DEN_W-1:0]        out_den_out;

  int mismatches, pending, n_ok, n_div_zero, n_den_zero;
  int idle_pct, requests_sent, directed_sent, stall_cycles;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_num_a(in_num_a), .in_den_a(in_den_a),
    .in_num_b(in_num_b), .in_den_b(in_den_b),
    .out_valid(out_valid), .out_status(out_status),
    .out_num_out(out_num_out), .out_den_out(out_den_out)
  );

  rau_tb_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_num_a(in_num_a), .in_den_a(in_den_a),
    .in_num_b(in_num_b), .in_den_b(in_den_b),
    .out_valid(out_valid), .out_status(out_status),
    .out_num_out(out_num_out), .out_den_out(out_den_out),
    .mismatches(mismatches), .pending(pending), .n_ok(n_ok),
    .n_div_zero(n_div_zero), .n_den_zero(n_den_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] pick_operand();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'hffff;
          3:       return 16'h0001;
          default: return 16'h0000;
        endcase
      end
      1, 2, 3: return IN_W'(int'($urandom_range(40)) - 20);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic send_request(input action_t act, input logic [IN_W-1:0] na,
                              input logic [IN_W-1:0] da, input logic [IN_W-1:0] nb,
                              input logic [IN_W-1:0] db);
    int gap;
    start <= 1'b1;
    in_action <= act;
    in_num_a <= na;
    in_den_a <= da;
    in_num_b <= nb;
    in_den_b <= db;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      in_action <= 2'($urandom_range(3));
      in_num_a <= IN_W'($urandom);
      in_den_a <= IN_W'($urandom);
      in_num_b <= IN_W'($urandom);
      in_den_b <= IN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    action_t                act;
    logic [IN_W-1:0]        na, da, nb, db;
    int                     phase_pct;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_ADD;
    in_num_a <= '0;
    in_den_a <= '0;
    in_num_b <= '0;
    in_den_b <= '0;
    idle_pct = 0;
    requests_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_request(ACT_ADD, 16'h0001, 16'h0002, 16'h0001, 16'h0003);
    send_request(ACT_SUB, 16'h0001, 16'h0002, 16'h0001, 16'h0002);
    send_request(ACT_MUL, 16'h0006, 16'hfffc, 16'hfffd, 16'h0009);
    send_request(ACT_DIV, 16'h0003, 16'h0004, 16'hfffe, 16'h0005);
    send_request(ACT_ADD, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001);
    send_request(ACT_SUB, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);
    send_request(ACT_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    send_request(ACT_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_request(ACT_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_request(ACT_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_request(ACT_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(ACT_ADD, 16'h0005, 16'h0000, 16'h0001, 16'h0002);
    send_request(ACT_SUB, 16'h0005, 16'h0003, 16'h0001, 16'h0000);
    send_request(ACT_DIV, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DIV, 16'h0001, 16'h0002, 16'h0000, 16'h0003);
    send_request(ACT_DIV, 16'h0000, 16'h0002, 16'h0000, 16'h8000);
    send_request(ACT_ADD, 16'h0000, 16'h8000, 16'h0000, 16'h7fff);
    send_request(ACT_SUB, 16'h0003, 16'h0007, 16'h0003, 16'h0007);
    send_request(ACT_MUL, 16'h0000, 16'hffff, 16'h8000, 16'h8000);
    send_request(ACT_ADD, 16'h0001, 16'h8000, 16'hffff, 16'h8000);
    send_request(ACT_DIV, 16'hffff, 16'h7fff, 16'h8000, 16'hffff);
    directed_sent = requests_sent;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       phase_pct = 0;
        1:       phase_pct = 68;
        default: phase_pct = 10;
      endcase
      for (int i = 0; i < RANDOM_REQUESTS / 3; i++) begin
        idle_pct = (i % 60 < 10) ? 0 : phase_pct;
        act = action_t'($urandom_range(3));
        na = pick_operand();
        da = pick_operand();
        nb = pick_operand();
        db = pick_operand();
        if ($urandom_range(99) < 3) da = '0;
        if ($urandom_range(99) < 3) db = '0;
        if (act == ACT_DIV && $urandom_range(99) < 8) nb = '0;
        send_request(act, na, da, nb, db);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d requests, %0d of them directed, under no, heavy and light idling.",
             requests_sent, directed_sent);
    $display("Checked %0d results: %0d ok, %0d divide by zero, %0d zero denominator.",
             n_ok + n_div_zero + n_den_zero, n_ok, n_div_zero, n_den_zero);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_datapath.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/rau_checker.sv
verif/testbench.sv
